// File: rtl/lfs_pkg.sv
// ----------------------------------------------------------------------------
// lfs_pkg
// Types and constants shared by the log line field splitter modules.
// ----------------------------------------------------------------------------
package lfs_pkg;

  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_LBR   = 8'h5B;
  localparam logic [7:0] CHAR_RBR   = 8'h5D;
  localparam logic [7:0] CHAR_QUOTE = 8'h22;

  localparam int CHAR_W   = 8;
  localparam int FIELD_W  = 5;
  localparam int STATUS_W = 3;
  localparam int CFG_W    = 6;
  localparam int FIELD_HW_CAP = 32;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 3'd0,
    ST_UNMATCHED = 3'd1,
    ST_TOO_MANY  = 3'd2,
    ST_OPEN_NEST = 3'd3,
    ST_COUNT     = 3'd4,
    ST_OVERFLOW  = 3'd5,
    ST_SKIPPED   = 3'd6
  } lfs_status_t;

  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic              last;
    logic              is_space;
    logic              is_lbr;
    logic              is_rbr;
    logic              is_quote;
  } lfs_item_t;

  typedef struct packed {
    logic [CHAR_W-1:0]  ch;
    logic [FIELD_W-1:0] field_number;
    logic               is_separator;
    lfs_status_t        status;
    logic               line_end;
  } lfs_result_t;

endpackage

// File: rtl/log_line_field_splitter_top.sv
// ----------------------------------------------------------------------------
// log_line_field_splitter_top
// Tags each log-line byte with its field number, separator flag and status.
// ----------------------------------------------------------------------------
// Each input beat is registered in the queue, then in the back's output register.
// Throughput: one byte per cycle while out_tready does not hold back the output.
// Input stalls only when the two-entry queue is full.
// Reset: synchronous active-low; line-start state, number_of_fields = 9.
module log_line_field_splitter_top #(
  parameter int STACK_DEPTH = 8,
  parameter int MAX_FIELDS  = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] char_in
  input  logic        in_tlast,   // last_char
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [7:0] char_out, [12:8] field_number, [15:13] status
  output logic        out_tuser,  // is_separator
  output logic        out_tlast,  // line_end
  input  logic        cfg_we,
  input  logic [lfs_pkg::CFG_W-1:0] cfg_wdata
);
  import lfs_pkg::*;

  logic        push;
  logic        pop;
  logic        full;
  logic        empty;
  lfs_item_t   push_item;
  lfs_item_t   pop_item;
  lfs_result_t res;

  lfs_front u_front (
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .push       (push),
    .push_item  (push_item),
    .queue_full (full)
  );

  lfs_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .full      (full),
    .pop       (pop),
    .empty     (empty),
    .pop_item  (pop_item)
  );

  lfs_back #(
    .STACK_DEPTH (STACK_DEPTH),
    .MAX_FIELDS  (MAX_FIELDS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .empty     (empty),
    .pop       (pop),
    .pop_item  (pop_item),
    .res_valid (out_tvalid),
    .res_ready (out_tready),
    .res       (res)
  );

  assign out_tdata = {res.status, res.field_number, res.ch};
  assign out_tuser = res.is_separator;
  assign out_tlast = res.line_end;

endmodule

// File: rtl/lfs_front.sv
// ----------------------------------------------------------------------------
// lfs_front
// Input side: accept a byte and classify it as space, bracket or quote.
// ----------------------------------------------------------------------------
module lfs_front (
  input  logic                       in_tvalid,
  output logic                       in_tready,
  input  logic [lfs_pkg::CHAR_W-1:0] in_tdata,
  input  logic                       in_tlast,
  output logic                       push,
  output lfs_pkg::lfs_item_t         push_item,
  input  logic                       queue_full
);
  import lfs_pkg::*;

  assign in_tready = !queue_full;
  assign push      = in_tvalid && !queue_full;

  always_comb begin
    push_item          = '0;
    push_item.ch       = in_tdata;
    push_item.last     = in_tlast;
    push_item.is_space = (in_tdata == CHAR_SPACE);
    push_item.is_lbr   = (in_tdata == CHAR_LBR);
    push_item.is_rbr   = (in_tdata == CHAR_RBR);
    push_item.is_quote = (in_tdata == CHAR_QUOTE);
  end

endmodule

// File: rtl/lfs_queue.sv
// ----------------------------------------------------------------------------
// lfs_queue
// Two-entry queue of classified beats between the front and back.
// ----------------------------------------------------------------------------
module lfs_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  lfs_pkg::lfs_item_t push_item,
  output logic               full,
  input  logic               pop,
  output logic               empty,
  output lfs_pkg::lfs_item_t pop_item
);
  import lfs_pkg::*;

  lfs_item_t   mem_r [2];
  logic        wr_ptr_r, wr_ptr_nxt;
  logic        rd_ptr_r, rd_ptr_nxt;
  logic [1:0]  count_r, count_nxt;

  assign full     = (count_r == 2'd2);
  assign empty    = (count_r == 2'd0);
  assign pop_item = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = !wr_ptr_r;
    end
    if (pop) begin
      rd_ptr_nxt = !rd_ptr_r;
    end
    unique case ({push, pop})
      2'b10:   count_nxt = count_r + 2'd1;
      2'b01:   count_nxt = count_r - 2'd1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

// File: rtl/lfs_back.sv
// ----------------------------------------------------------------------------
// lfs_back
// Line state update: nesting stack, field count, quote close, end checks,
// and the output register.
// ----------------------------------------------------------------------------
module lfs_back #(
  parameter int STACK_DEPTH = 8,
  parameter int MAX_FIELDS  = 32
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_we,
  input  logic [lfs_pkg::CFG_W-1:0] cfg_wdata,
  input  logic                      empty,
  output logic                      pop,
  input  lfs_pkg::lfs_item_t        pop_item,
  output logic                      res_valid,
  input  logic                      res_ready,
  output lfs_pkg::lfs_result_t      res
);
  import lfs_pkg::*;

  localparam int CNT_W = $clog2(STACK_DEPTH + 1);
  localparam int IDX_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int CAP   = (MAX_FIELDS < FIELD_HW_CAP) ? MAX_FIELDS : FIELD_HW_CAP;
  localparam logic [CFG_W-1:0] CAP_V   = CAP[CFG_W-1:0];
  localparam logic [CNT_W-1:0] DEPTH_V = STACK_DEPTH[CNT_W-1:0];

  logic [STACK_DEPTH-1:0] stack_r;
  logic [CNT_W-1:0]       depth_r, depth_nxt;
  logic [FIELD_W-1:0]     fcnt_r, fcnt_nxt;
  logic                   prev_space_r, prev_space_nxt;
  logic                   pend_r, pend_nxt;
  logic                   abort_r, abort_nxt;
  logic [CFG_W-1:0]       nfields_r;
  logic                   res_valid_r;
  lfs_result_t            res_r, res_nxt;

  logic [CFG_W-1:0] eff;
  logic [CNT_W-1:0] top_idx;
  logic             top_bit;
  logic             push_en;
  logic             push_kind;
  logic             minor;
  lfs_status_t      st;
  lfs_item_t        it;

  assign pop       = !empty && (!res_valid_r || res_ready);
  assign res_valid = res_valid_r;
  assign res       = res_r;
  assign it        = pop_item;
  assign top_idx   = depth_r - CNT_W'(1);
  assign top_bit   = stack_r[top_idx[IDX_W-1:0]];

  always_comb begin
    if (nfields_r == '0) begin
      eff = CFG_W'(1);
    end else if (nfields_r > CAP_V) begin
      eff = CAP_V;
    end else begin
      eff = nfields_r;
    end
  end

  always_comb begin
    depth_nxt      = depth_r;
    fcnt_nxt       = fcnt_r;
    pend_nxt       = pend_r;
    abort_nxt      = abort_r;
    prev_space_nxt = it.is_space;
    push_en        = 1'b0;
    push_kind      = 1'b0;
    minor          = 1'b0;
    st             = ST_OK;
    res_nxt              = '0;
    res_nxt.ch           = it.ch;
    res_nxt.field_number = fcnt_r;
    res_nxt.line_end     = it.last;

    if (abort_r) begin
      st = ST_SKIPPED;
    end else begin
      pend_nxt = 1'b0;
      if (pend_r && it.is_space) begin
        if (depth_r != '0 && top_bit) begin
          depth_nxt = depth_r - CNT_W'(1);
        end else begin
          minor = 1'b1;
        end
      end

      priority if (it.is_space) begin
        if (!it.last && depth_nxt == '0) begin
          if ({1'b0, fcnt_r} + CFG_W'(1) >= eff) begin
            st = ST_TOO_MANY;
          end else begin
            res_nxt.is_separator = 1'b1;
            fcnt_nxt = fcnt_r + FIELD_W'(1);
          end
        end
      end else if (it.is_lbr) begin
        if (depth_r >= DEPTH_V) begin
          st = ST_OVERFLOW;
        end else begin
          push_en   = 1'b1;
          push_kind = 1'b0;
          depth_nxt = depth_r + CNT_W'(1);
        end
      end else if (it.is_rbr) begin
        if (depth_r != '0 && !top_bit) begin
          depth_nxt = depth_r - CNT_W'(1);
        end
      end else if (it.is_quote) begin
        if (prev_space_r) begin
          if (depth_r >= DEPTH_V) begin
            st = ST_OVERFLOW;
          end else begin
            push_en   = 1'b1;
            push_kind = 1'b1;
            depth_nxt = depth_r + CNT_W'(1);
          end
        end else if (it.last) begin
          if (depth_r != '0 && top_bit) begin
            depth_nxt = depth_r - CNT_W'(1);
          end else begin
            minor = 1'b1;
          end
        end else begin
          pend_nxt = 1'b1;
        end
      end else begin
        pend_nxt = 1'b0;
      end

      if (st != ST_OK) begin
        abort_nxt = 1'b1;
        pend_nxt  = 1'b0;
      end else if (it.last) begin
        if (depth_nxt != '0) begin
          st = ST_OPEN_NEST;
        end else if ({1'b0, fcnt_nxt} != eff - CFG_W'(1)) begin
          st = ST_COUNT;
        end
      end
      if (st == ST_OK && minor) begin
        st = ST_UNMATCHED;
      end
    end

    res_nxt.status = st;

    if (it.last) begin
      depth_nxt      = '0;
      fcnt_nxt       = '0;
      prev_space_nxt = 1'b1;
      pend_nxt       = 1'b0;
      abort_nxt      = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      depth_r      <= '0;
      fcnt_r       <= '0;
      prev_space_r <= 1'b1;
      pend_r       <= 1'b0;
      abort_r      <= 1'b0;
      nfields_r    <= CFG_W'(9);
      res_valid_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        nfields_r <= cfg_wdata;
      end
      if (pop) begin
        depth_r      <= depth_nxt;
        fcnt_r       <= fcnt_nxt;
        prev_space_r <= prev_space_nxt;
        pend_r       <= pend_nxt;
        abort_r      <= abort_nxt;
        res_valid_r  <= 1'b1;
      end else if (res_ready) begin
        res_valid_r  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      res_r <= res_nxt;
      if (push_en) begin
        stack_r[depth_r[IDX_W-1:0]] <= push_kind;
      end
    end
  end

endmodule
